/* src/amo_pkg.sv */
// Shared types and constants for the atomic memory op unit.
// No dependencies; every other file uses it through scoped names.
`timescale 1ns / 1ps

package amo_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // request kinds
  localparam logic [3:0] OP_LR    = 4'd0;
  localparam logic [3:0] OP_SC    = 4'd1;
  localparam logic [3:0] OP_SWAP  = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_AND   = 4'd4;
  localparam logic [3:0] OP_OR    = 4'd5;
  localparam logic [3:0] OP_XOR   = 4'd6;
  localparam logic [3:0] OP_MAX   = 4'd7;
  localparam logic [3:0] OP_MIN   = 4'd8;
  localparam logic [3:0] OP_MAXU  = 4'd9;
  localparam logic [3:0] OP_MINU  = 4'd10;
  localparam logic [3:0] OP_LOAD  = 4'd11;
  localparam logic [3:0] OP_STORE = 4'd12;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [9:0]  word_addr;
    logic [31:0] operand;
  } amo_req_t;

  typedef struct packed {
    logic [31:0] rd_value;
    logic        mem_written;
  } amo_rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic              take;       // capture request, start memory read
    logic              commit;     // compute, write back, load result
    logic              clear;      // write zero during the clearing pass
    logic [MEM_AW-1:0] clear_addr;
  } amo_cmd_t;

endpackage

/* src/atomic_memory_op_unit.sv */
// Top level of the atomic memory op unit: RV32A word atomics on a local
// word memory. Depends on amo_pkg, amo_ctrl and amo_dpath.
`timescale 1ns / 1ps

// Usage
// - req channel: one beat carries req_type, word_addr and operand. A beat
//   is taken when req_valid is high and req_stall is low.
// - rsp channel: one beat per request with rd_value (old word, loaded word
//   or SC status) and mem_written. Taken when rsp_valid high, rsp_stall low.
// - A taken request first reads its memory word into a register; when the
//   response register is free it is computed, written back and answered.
// - Requests are worked one at a time: req_stall stays high from the take
//   until that request is committed, then the next one may be taken.
// - Reset: rst is synchronous. It drops the reservation and starts a
//   clearing pass that zeroes all MEM_WORDS (1024) words of the memory;
//   req_stall stays high until that pass ends.
// - Receiver stall: the response register holds its beat while rsp_stall
//   is high. A following request is still taken and read; its write-back
//   waits until the response register frees, so no beat is lost.
// - Word addresses wrap modulo MEM_WORDS. Kinds 13 to 15 answer zero and
//   touch nothing.

module atomic_memory_op_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  amo_pkg::amo_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output amo_pkg::amo_rsp_t rsp
);

  amo_pkg::amo_cmd_t cmd;

  // sequencing: clearing pass, accept, commit when response slot frees
  amo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // memory, reservation and AMO arithmetic
  amo_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

/* src/amo_ctrl.sv */
// Controller for the atomic memory op unit: clearing pass, request
// sequencing and result valid. Depends on amo_pkg.
`timescale 1ns / 1ps

module amo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output amo_pkg::amo_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                     state;
  logic [amo_pkg::MEM_AW-1:0] clr_cnt;
  logic                       out_busy;

  assign out_busy  = rsp_valid && rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd.take       = (state == ST_IDLE) && req_valid;
    cmd.commit     = (state == ST_EXEC) && !out_busy;
    cmd.clear      = (state == ST_CLEAR);
    cmd.clear_addr = clr_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == amo_pkg::MEM_AW'(amo_pkg::MEM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

/* src/amo_dpath.sv */
// Datapath for the atomic memory op unit: word memory, request register,
// reservation, AMO ALU and result register. Depends on amo_pkg.
`timescale 1ns / 1ps

module amo_dpath (
  input  logic              clk,
  input  logic              rst,
  input  amo_pkg::amo_cmd_t cmd,
  input  amo_pkg::amo_req_t req,
  output amo_pkg::amo_rsp_t rsp
);

  logic [31:0]                mem [amo_pkg::MEM_WORDS];
  logic [31:0]                rdata;
  amo_pkg::amo_req_t          cur;
  logic                       res_valid;
  logic [9:0]                 res_addr;

  logic                       wr_en;
  logic [amo_pkg::MEM_AW-1:0] wr_addr;
  logic [31:0]                wr_data;
  logic [31:0]                newv;
  logic [31:0]                rd_next;
  logic                       wrote_next;
  logic                       sc_ok;

  assign sc_ok = res_valid && (res_addr == cur.word_addr);

  always_comb begin
    newv       = cur.operand;
    rd_next    = 32'd0;
    wrote_next = 1'b0;
    case (cur.req_type)
      amo_pkg::OP_SWAP: newv = cur.operand;
      amo_pkg::OP_ADD:  newv = rdata + cur.operand;
      amo_pkg::OP_AND:  newv = rdata & cur.operand;
      amo_pkg::OP_OR:   newv = rdata | cur.operand;
      amo_pkg::OP_XOR:  newv = rdata ^ cur.operand;
      amo_pkg::OP_MAX:
        newv = ($signed(rdata) >= $signed(cur.operand)) ? rdata : cur.operand;
      amo_pkg::OP_MIN:
        newv = ($signed(rdata) <= $signed(cur.operand)) ? rdata : cur.operand;
      amo_pkg::OP_MAXU: newv = (rdata >= cur.operand) ? rdata : cur.operand;
      amo_pkg::OP_MINU: newv = (rdata <= cur.operand) ? rdata : cur.operand;
      default:          newv = cur.operand;
    endcase
    case (cur.req_type) inside
      [amo_pkg::OP_SWAP:amo_pkg::OP_MINU]: begin
        rd_next    = rdata;
        wrote_next = 1'b1;
      end
      amo_pkg::OP_LR, amo_pkg::OP_LOAD: begin
        rd_next = rdata;
      end
      amo_pkg::OP_SC: begin
        rd_next    = sc_ok ? 32'd0 : 32'd1;
        wrote_next = sc_ok;
      end
      amo_pkg::OP_STORE: begin
        wrote_next = 1'b1;
      end
      default: begin
        rd_next    = 32'd0;
        wrote_next = 1'b0;
      end
    endcase
  end

  // single write port shared by the clearing pass and write-back
  always_comb begin
    wr_en   = cmd.clear || (cmd.commit && wrote_next);
    wr_addr = cmd.clear ? cmd.clear_addr : cur.word_addr[amo_pkg::MEM_AW-1:0];
    wr_data = cmd.clear ? 32'd0 : newv;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.take) begin
      rdata <= mem[req.word_addr[amo_pkg::MEM_AW-1:0]];
      cur   <= req;
    end
    if (cmd.commit) begin
      rsp.rd_value    <= rd_next;
      rsp.mem_written <= wrote_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_addr  <= '0;
    end else if (cmd.commit) begin
      if (cur.req_type == amo_pkg::OP_LR) begin
        res_valid <= 1'b1;
        res_addr  <= cur.word_addr;
      end else if (cur.req_type == amo_pkg::OP_SC) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
